// File: rtl/pes_pkg.sv
// shared types, codes and constants for the pes header parser
`timescale 1ns / 1ps
`default_nettype none

package pes_pkg;

   // width of the byte counters
   localparam int COUNT_BITS = 24;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // width and saturation of the reported payload size
   localparam int SIZE_BITS = 24;
   localparam logic [31:0] SIZE_MAX32 = 32'h00FF_FFFF;

   // timestamps
   localparam int TS_BITS    = 33;
   localparam int TS_SHIFT_BITS = 40;
   localparam logic [7:0] TS_FIELD_BYTES = 8'd5;

   // start code and special stream ids
   localparam logic [7:0] START_ZERO_BYTE = 8'h00;
   localparam logic [7:0] START_ONE_BYTE  = 8'h01;
   localparam logic [7:0] SID_PADDING     = 8'hBE;
   localparam logic [7:0] SID_PRIVATE2    = 8'hBF;
   localparam logic [1:0] OPT_MARKER      = 2'b10;

   // byte positions inside the prefix and the timestamp fields
   localparam logic [3:0] POS_SID       = 4'd3;
   localparam logic [3:0] POS_LEN_HI    = 4'd4;
   localparam logic [3:0] POS_AFTER_PFX = 4'd6;
   localparam logic [3:0] POS_TS_END    = 4'd11;

   // flag byte bits
   localparam int FLAG_PTS = 7;
   localparam int FLAG_DTS = 6;

   // result queue depth
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [3:0] {
      PH_PREFIX  = 4'd0,
      PH_FLAGS1  = 4'd1,
      PH_FLAGS2  = 4'd2,
      PH_HLEN    = 4'd3,
      PH_PTS     = 4'd4,
      PH_DTS     = 4'd5,
      PH_SKIP    = 4'd6,
      PH_PAYLOAD = 4'd7,
      PH_DISCARD = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_BAD_START    = 3'd1,
      ST_LEN_MISMATCH = 3'd2,
      ST_BAD_MARKER   = 3'd3,
      ST_HDR_SHORT    = 3'd4,
      ST_TRUNCATED    = 3'd5
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic                 result_kind;
      logic [7:0]           payload_byte;
      logic [7:0]           stream_id;
      logic [1:0]           scramble_ctrl;
      logic [3:0]           header_flag_bits;
      logic                 has_pts;
      logic                 has_dts;
      logic [TS_BITS-1:0]   pts;
      logic [TS_BITS-1:0]   dts;
      logic [SIZE_BITS-1:0] payload_count;
      logic [2:0]           status;
      logic                 result_last;
   } rsp_type;

   // one queue word: an optional payload byte and an optional summary
   typedef struct packed {
      logic       pay_valid;
      logic [7:0] pay_byte;
      logic       sum_valid;
      rsp_type    sum;
   } entry_type;

endpackage

`default_nettype wire

// File: rtl/pes_front.sv
// front end: byte parser that classifies each byte and builds queue words
`timescale 1ns / 1ps
`default_nettype none

module pes_front (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic req_valid,
   input  wire pes_pkg::req_type req_data,
   input  wire                logic queue_full,
   output logic               push_valid,
   output pes_pkg::entry_type push_data
);
   import pes_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [3:0]             pos_ff, pos_in;
   logic [15:0]            decl_len_ff, decl_len_in;
   logic [7:0]             hdr_left_ff, hdr_left_in;
   logic [TS_SHIFT_BITS-1:0] ts_ff, ts_in;
   logic [7:0]             sid_ff, sid_in;
   logic [7:0]             flags_ff, flags_in;
   logic [TS_BITS-1:0]     pts_ff, pts_in;
   logic [TS_BITS-1:0]     dts_ff, dts_in;
   logic [COUNT_BITS-1:0]  apc_ff, apc_in;
   logic [COUNT_BITS-1:0]  pcnt_ff, pcnt_in;
   status_type             err_ff, err_in;

   logic                   accept;
   logic [7:0]             b;
   logic [TS_BITS-1:0]     ts_val;
   logic [31:0]            pcnt_wide;
   status_type             st;

   assign accept = req_valid && !queue_full;
   assign b      = req_data.data_byte;

   // parse state update, one byte per cycle while the queue is not full
   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      decl_len_in = decl_len_ff;
      hdr_left_in = hdr_left_ff;
      ts_in       = ts_ff;
      sid_in      = sid_ff;
      flags_in    = flags_ff;
      pts_in      = pts_ff;
      dts_in      = dts_ff;
      apc_in      = apc_ff;
      pcnt_in     = pcnt_ff;
      err_in      = err_ff;
      ts_val      = '0;
      pcnt_wide   = '0;
      st          = ST_OK;
      push_valid  = 1'b0;
      push_data   = '0;

      if (accept) begin
         // bytes after the length field
         if (pos_ff >= POS_AFTER_PFX && apc_ff != COUNT_MAX) begin
            apc_in = apc_ff + 1'b1;
         end

         case (phase_ff)
            PH_PREFIX: begin
               if ((pos_ff <= 4'd1 && b != START_ZERO_BYTE) ||
                   (pos_ff == 4'd2 && b != START_ONE_BYTE)) begin
                  if (err_in == ST_OK) err_in = ST_BAD_START;
                  phase_in = PH_DISCARD;
               end else begin
                  if (pos_ff == POS_SID) begin
                     sid_in = b;
                  end else if (pos_ff == POS_LEN_HI) begin
                     decl_len_in = {b, 8'h00};
                  end else if (pos_ff > POS_LEN_HI) begin
                     decl_len_in = decl_len_ff | {8'h00, b};
                  end
                  pos_in = pos_ff + 1'b1;
                  if (pos_in == POS_AFTER_PFX) begin
                     phase_in = (sid_in == SID_PADDING || sid_in == SID_PRIVATE2) ?
                                PH_PAYLOAD : PH_FLAGS1;
                  end
               end
            end
            PH_FLAGS1: begin
               if (b[7:6] != OPT_MARKER) begin
                  if (err_in == ST_OK) err_in = ST_BAD_MARKER;
                  phase_in = PH_DISCARD;
               end else begin
                  flags_in = {2'b00, b[5:0]};
                  phase_in = PH_FLAGS2;
               end
            end
            PH_FLAGS2: begin
               flags_in = flags_ff | {b[7:6], 6'b000000};
               phase_in = PH_HLEN;
            end
            PH_HLEN: begin
               hdr_left_in = b;
               if (flags_ff[FLAG_PTS] || flags_ff[FLAG_DTS]) begin
                  if (hdr_left_in < TS_FIELD_BYTES) begin
                     if (err_in == ST_OK) err_in = ST_HDR_SHORT;
                     phase_in = PH_DISCARD;
                  end else begin
                     ts_in    = '0;
                     pos_in   = POS_AFTER_PFX;
                     phase_in = flags_ff[FLAG_PTS] ? PH_PTS : PH_DTS;
                  end
               end else begin
                  phase_in = (hdr_left_in == 8'd0) ? PH_PAYLOAD : PH_SKIP;
               end
            end
            PH_PTS, PH_DTS: begin
               ts_in  = {ts_ff[TS_SHIFT_BITS-9:0], b};
               pos_in = pos_ff + 1'b1;
               if (pos_in >= POS_TS_END) begin
                  pos_in      = POS_AFTER_PFX;
                  hdr_left_in = hdr_left_ff - TS_FIELD_BYTES;
                  ts_val      = {ts_in[35:33], ts_in[31:17], ts_in[15:1]};
                  if (phase_ff == PH_PTS) begin
                     pts_in = ts_val;
                  end else begin
                     dts_in = ts_val;
                  end
                  if (phase_ff == PH_PTS && flags_ff[FLAG_DTS]) begin
                     // dts field follows the pts field
                     if (hdr_left_in < TS_FIELD_BYTES) begin
                        if (err_in == ST_OK) err_in = ST_HDR_SHORT;
                        phase_in = PH_DISCARD;
                     end else begin
                        ts_in    = '0;
                        phase_in = PH_DTS;
                     end
                  end else begin
                     phase_in = (hdr_left_in == 8'd0) ? PH_PAYLOAD : PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               hdr_left_in = hdr_left_ff - 1'b1;
               if (hdr_left_in == 8'd0) phase_in = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               push_data.pay_valid = 1'b1;
               push_data.pay_byte  = b;
               if (pcnt_ff != COUNT_MAX) pcnt_in = pcnt_ff + 1'b1;
            end
            default: begin
            end
         endcase

         // end of packet summary
         if (req_data.last_byte) begin
            if (err_in == ST_BAD_START) begin
               st = ST_BAD_START;
            end else if (pos_in < POS_AFTER_PFX) begin
               st = ST_TRUNCATED;
            end else if (decl_len_in != 16'd0 &&
                         apc_in != COUNT_BITS'(decl_len_in)) begin
               st = ST_LEN_MISMATCH;
            end else if (err_in != ST_OK) begin
               st = err_in;
            end else if (phase_in != PH_PAYLOAD) begin
               st = ST_TRUNCATED;
            end else begin
               st = ST_OK;
            end
            pcnt_wide = 32'(pcnt_in);
            push_data.sum_valid              = 1'b1;
            push_data.sum.result_kind        = KIND_SUMMARY;
            push_data.sum.stream_id          = sid_in;
            push_data.sum.scramble_ctrl      = flags_in[5:4];
            push_data.sum.header_flag_bits   = flags_in[3:0];
            push_data.sum.has_pts            = flags_in[FLAG_PTS];
            push_data.sum.has_dts            = flags_in[FLAG_DTS];
            push_data.sum.pts                = pts_in;
            push_data.sum.dts                = dts_in;
            push_data.sum.payload_count      = (pcnt_wide > SIZE_MAX32) ?
                                               SIZE_MAX32[SIZE_BITS-1:0] :
                                               pcnt_wide[SIZE_BITS-1:0];
            push_data.sum.status             = st;
            push_data.sum.result_last        = 1'b1;

            // back to the reset state for the next packet
            phase_in    = PH_PREFIX;
            pos_in      = '0;
            decl_len_in = '0;
            hdr_left_in = '0;
            ts_in       = '0;
            sid_in      = '0;
            flags_in    = '0;
            pts_in      = '0;
            dts_in      = '0;
            apc_in      = '0;
            pcnt_in     = '0;
            err_in      = ST_OK;
         end

         push_valid = push_data.pay_valid || push_data.sum_valid;
      end
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_PREFIX;
         pos_ff      <= '0;
         decl_len_ff <= '0;
         hdr_left_ff <= '0;
         ts_ff       <= '0;
         sid_ff      <= '0;
         flags_ff    <= '0;
         pts_ff      <= '0;
         dts_ff      <= '0;
         apc_ff      <= '0;
         pcnt_ff     <= '0;
         err_ff      <= ST_OK;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         decl_len_ff <= decl_len_in;
         hdr_left_ff <= hdr_left_in;
         ts_ff       <= ts_in;
         sid_ff      <= sid_in;
         flags_ff    <= flags_in;
         pts_ff      <= pts_in;
         dts_ff      <= dts_in;
         apc_ff      <= apc_in;
         pcnt_ff     <= pcnt_in;
         err_ff      <= err_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/pes_queue.sv
// short word queue between the parser and the result stage
`timescale 1ns / 1ps
`default_nettype none

module pes_queue (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic push_valid,
   input  wire pes_pkg::entry_type push_data,
   output logic               full,
   input  wire                logic pop,
   output logic               head_valid,
   output pes_pkg::entry_type head_data
);
   import pes_pkg::*;

   entry_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wptr_ff, wptr_in;
   logic [QUEUE_AW-1:0]   rptr_ff, rptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

   // the parser never pushes into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push_valid && full))
      else $error("push into full queue");

   // fill count stays within the depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("queue count out of range");

   // a push without a pop grows the count by one
   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not grow");

   // every queued word carries at least one result
   a_word_nonempty: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (push_data.pay_valid || push_data.sum_valid))
      else $error("empty word pushed");

endmodule

`default_nettype wire

// File: rtl/pes_back.sv
// back end: expands queue words into result words in an output register
`timescale 1ns / 1ps
`default_nettype none

module pes_back (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic head_valid,
   input  wire pes_pkg::entry_type head_data,
   output logic               pop,
   output logic               rsp_valid,
   input  wire                logic rsp_stall,
   output pes_pkg::rsp_type   rsp_data
);
   import pes_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    half_ff, half_in;
   logic    load;

   assign load      = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // pick payload first, then the summary of the same word
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      half_in      = half_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            if (head_data.pay_valid && !half_ff) begin
               rsp_in              = '0;
               rsp_in.result_kind  = KIND_PAYLOAD;
               rsp_in.payload_byte = head_data.pay_byte;
               rsp_in.result_last  = !head_data.sum_valid;
               half_in             = head_data.sum_valid;
               pop                 = !head_data.sum_valid;
            end else begin
               rsp_in  = head_data.sum;
               half_in = 1'b0;
               pop     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         half_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         half_ff      <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

// File: rtl/pes_header_parser.sv
// pes header parser top level: parser, word queue and result stage
// path: each input word goes into the queue, and the output register loads from its head
// throughput: one input word per cycle while the queue is not full
// a final byte inside the payload yields two results, the payload byte, then the summary
// a four-word queue takes parser words during output stalls until it is full
// reset: synchronous; clears parse state, queue pointers and output valid
`timescale 1ns / 1ps
`default_nettype none

module pes_header_parser (
   input  wire              logic clock,
   input  wire              logic reset,
   input  wire              logic req_valid,
   output logic             req_stall,
   input  wire pes_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              logic rsp_stall,
   output pes_pkg::rsp_type rsp_data
);
   import pes_pkg::*;

   logic      push_valid;
   entry_type push_data;
   logic      queue_full;
   logic      pop;
   logic      head_valid;
   entry_type head_data;

   assign req_stall = queue_full;

   // byte parser
   pes_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // word queue
   pes_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // result stage
   pes_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// File: test/pes_result_checker.sv
// checker for the pes header parser: predicts every result word and compares it
`timescale 1ns / 1ps

module pes_result_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  pes_pkg::req_type req_data,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  pes_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               expect_count,
   output int               checked_count
);
   import pes_pkg::*;

   // parse state mirrored from the block
   phase_type                 phase;
   logic [3:0]                pos;
   logic [15:0]               decl_len;
   logic [7:0]                hdr_left;
   logic [TS_SHIFT_BITS-1:0]  ts_shift;
   logic [7:0]                sid;
   logic [7:0]                flags;
   logic [TS_BITS-1:0]        pts_held;
   logic [TS_BITS-1:0]        dts_held;
   logic [COUNT_BITS-1:0]     after_cnt;
   logic [COUNT_BITS-1:0]     pay_cnt;
   status_type                first_err;

   // result words still owed by the block, oldest first
   rsp_type expected_words[$];

   initial begin
      fail_count    = 0;
      expect_count  = 0;
      checked_count = 0;
   end

   task automatic clear_parse();
      phase     = PH_PREFIX;
      pos       = '0;
      decl_len  = '0;
      hdr_left  = '0;
      ts_shift  = '0;
      sid       = '0;
      flags     = '0;
      pts_held  = '0;
      dts_held  = '0;
      after_cnt = '0;
      pay_cnt   = '0;
      first_err = ST_OK;
   endtask

   task automatic note_error(input status_type code);
      if (first_err == ST_OK) begin
         first_err = code;
      end
      phase = PH_DISCARD;
   endtask

   // 33-bit timestamp from the five field bytes, marker bits dropped
   function automatic logic [TS_BITS-1:0] ts_value(input logic [TS_SHIFT_BITS-1:0] t);
      return {t[35:33], t[31:17], t[15:1]};
   endfunction

   task automatic after_header();
      phase = (hdr_left == 8'd0) ? PH_PAYLOAD : PH_SKIP;
   endtask

   // a timestamp field needs five header bytes left
   task automatic open_timestamp(input phase_type ts_phase);
      if (hdr_left < TS_FIELD_BYTES) begin
         note_error(ST_HDR_SHORT);
      end else begin
         ts_shift = '0;
         pos      = POS_AFTER_PFX;
         phase    = ts_phase;
      end
   endtask

   // advance the parse by one byte and queue the results it causes
   task automatic parse_byte(input logic [7:0] b, input logic last);
      rsp_type    r;
      status_type st;
      if (pos >= POS_AFTER_PFX && after_cnt != COUNT_MAX) begin
         after_cnt = after_cnt + 1'b1;
      end
      case (phase)
         PH_PREFIX: begin
            if ((pos <= 4'd1 && b != START_ZERO_BYTE) ||
                (pos == 4'd2 && b != START_ONE_BYTE)) begin
               note_error(ST_BAD_START);
            end else begin
               if (pos == POS_SID) begin
                  sid = b;
               end else if (pos == POS_LEN_HI) begin
                  decl_len = {b, 8'h00};
               end else if (pos > POS_LEN_HI) begin
                  decl_len = decl_len | {8'h00, b};
               end
               pos = pos + 1'b1;
               if (pos == POS_AFTER_PFX) begin
                  if (sid == SID_PADDING || sid == SID_PRIVATE2) begin
                     phase = PH_PAYLOAD;
                  end else begin
                     phase = PH_FLAGS1;
                  end
               end
            end
         end
         PH_FLAGS1: begin
            if (b[7:6] != OPT_MARKER) begin
               note_error(ST_BAD_MARKER);
            end else begin
               flags = {2'b00, b[5:0]};
               phase = PH_FLAGS2;
            end
         end
         PH_FLAGS2: begin
            flags = flags | {b[7:6], 6'b0};
            phase = PH_HLEN;
         end
         PH_HLEN: begin
            hdr_left = b;
            if (flags[FLAG_PTS]) begin
               open_timestamp(PH_PTS);
            end else if (flags[FLAG_DTS]) begin
               open_timestamp(PH_DTS);
            end else begin
               after_header();
            end
         end
         PH_PTS, PH_DTS: begin
            ts_shift = {ts_shift[TS_SHIFT_BITS-9:0], b};
            pos = pos + 1'b1;
            if (pos >= POS_TS_END) begin
               pos = POS_AFTER_PFX;
               hdr_left = hdr_left - TS_FIELD_BYTES;
               if (phase == PH_PTS) begin
                  pts_held = ts_value(ts_shift);
                  if (flags[FLAG_DTS]) begin
                     open_timestamp(PH_DTS);
                  end else begin
                     after_header();
                  end
               end else begin
                  dts_held = ts_value(ts_shift);
                  after_header();
               end
            end
         end
         PH_SKIP: begin
            hdr_left = hdr_left - 1'b1;
            if (hdr_left == 8'd0) begin
               phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            r = '0;
            r.result_kind  = KIND_PAYLOAD;
            r.payload_byte = b;
            r.result_last  = !last;
            expected_words.push_back(r);
            if (pay_cnt != COUNT_MAX) begin
               pay_cnt = pay_cnt + 1'b1;
            end
         end
         default: begin
         end
      endcase

      // final byte: end-of-packet summary, then back to the start code
      if (last) begin
         if (first_err == ST_BAD_START) begin
            st = ST_BAD_START;
         end else if (pos < POS_AFTER_PFX) begin
            st = ST_TRUNCATED;
         end else if (decl_len != 16'd0 && after_cnt != decl_len) begin
            st = ST_LEN_MISMATCH;
         end else if (first_err != ST_OK) begin
            st = first_err;
         end else if (phase != PH_PAYLOAD) begin
            st = ST_TRUNCATED;
         end else begin
            st = ST_OK;
         end
         r = '0;
         r.result_kind        = KIND_SUMMARY;
         r.stream_id          = sid;
         r.scramble_ctrl      = flags[5:4];
         r.header_flag_bits   = flags[3:0];
         r.has_pts            = flags[FLAG_PTS];
         r.has_dts            = flags[FLAG_DTS];
         r.pts                = pts_held;
         r.dts                = dts_held;
         r.payload_count      = (32'(pay_cnt) > SIZE_MAX32) ?
                                SIZE_BITS'(SIZE_MAX32) : SIZE_BITS'(pay_cnt);
         r.status             = st;
         r.result_last        = 1'b1;
         expected_words.push_back(r);
         clear_parse();
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_words.size() == 0) begin
         $error("result word with nothing expected: %p", got);
         fail_count++;
         return;
      end
      want = expected_words.pop_front();
      checked_count++;
      check_field("result_kind", want.result_kind, got.result_kind);
      check_field("payload_byte", want.payload_byte, got.payload_byte);
      check_field("stream_id", want.stream_id, got.stream_id);
      check_field("scramble_ctrl", want.scramble_ctrl, got.scramble_ctrl);
      check_field("header_flag_bits", want.header_flag_bits, got.header_flag_bits);
      check_field("has_pts", want.has_pts, got.has_pts);
      check_field("has_dts", want.has_dts, got.has_dts);
      check_field("pts", want.pts, got.pts);
      check_field("dts", want.dts, got.dts);
      check_field("payload_count", want.payload_count, got.payload_count);
      check_field("status", want.status, got.status);
      check_field("result_last", want.result_last, got.result_last);
   endtask

   // watch both channels at the rising edge; inputs are predicted before results are checked
   always @(posedge clock) begin
      if (reset) begin
         clear_parse();
         expected_words.delete();
      end else begin
         if (req_valid && !req_stall) begin
            parse_byte(req_data.data_byte, req_data.last_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            check_result(rsp_data);
         end
      end
      expect_count = expected_words.size();
   end

endmodule

// File: test/testbench.sv
// testbench top for the pes header parser: packet stimulus, flow control and verdict
`timescale 1ns / 1ps

module testbench;
   import pes_pkg::*;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int expect_count;
   int checked_count;

   // idle and stall mix of each traffic phase, in percent
   int send_mix[4]  = '{0, 88, 0, 11};
   int stall_mix[4] = '{0, 0, 88, 11};
   int send_idle_pct = 0;
   int stall_pct     = 0;

   int packets_sent = 0;
   int bytes_sent   = 0;

   logic [7:0] pkt_bytes[$];

   pes_header_parser u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   pes_result_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .expect_count  (expect_count),
      .checked_count (checked_count)
   );

   always #10 clock = ~clock;

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // one word per handshake, with random idle cycles ahead of it
   task automatic send_word(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req_type'{data_byte: b, last_byte: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_packet();
      foreach (pkt_bytes[i]) begin
         send_word(pkt_bytes[i], i == pkt_bytes.size() - 1);
      end
      packets_sent++;
   endtask

   // hold the sender until every expected result has come out
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (expect_count != 0);
   endtask

   // random packet: mostly well formed, some truncated, corrupted or plain noise
   function automatic void build_random_packet();
      int          kind;
      int          need;
      int          hlen;
      int          n_pay;
      int          idx;
      int          cut;
      logic [7:0]  sid;
      logic [7:0]  f1;
      logic [7:0]  f2;
      logic [1:0]  pd;
      logic [1:0]  bad_mark;
      logic [15:0] len;
      logic [7:0]  body[$];
      kind = $urandom_range(99);
      pkt_bytes.delete();
      if (kind >= 94) begin
         repeat ($urandom_range(1, 12)) pkt_bytes.push_back(8'($urandom));
         return;
      end
      sid = 8'($urandom);
      if (kind >= 60 && kind < 70) begin
         sid = $urandom_range(1) ? SID_PADDING : SID_PRIVATE2;
      end else begin
         if (sid == SID_PADDING || sid == SID_PRIVATE2) begin
            sid = 8'hE0;
         end
         pd   = 2'($urandom);
         f1   = {OPT_MARKER, 6'($urandom)};
         f2   = {pd, 6'($urandom)};
         need = (pd[1] ? 5 : 0) + (pd[0] ? 5 : 0);
         hlen = need + (($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(3));
         if (kind >= 80 && kind < 88) begin
            if ($urandom_range(1)) begin
               bad_mark = 2'($urandom_range(2));
               if (bad_mark == OPT_MARKER) begin
                  bad_mark = 2'b11;
               end
               f1[7:6] = bad_mark;
            end else begin
               if (need == 0) begin
                  f2[7:6] = 2'b10;
                  need    = 5;
               end
               hlen = $urandom_range(need - 1);
            end
         end
         body.push_back(f1);
         body.push_back(f2);
         body.push_back(8'(hlen));
         repeat (hlen) body.push_back(8'($urandom));
      end
      n_pay = ($urandom_range(24) == 0) ? $urandom_range(100) : $urandom_range(12);
      repeat (n_pay) body.push_back(8'($urandom));
      case ($urandom_range(19))
         0, 1, 2, 3, 4: len = '0;
         5, 6, 7:       len = 16'($urandom);
         default:       len = 16'(body.size());
      endcase
      pkt_bytes = {START_ZERO_BYTE, START_ZERO_BYTE, START_ONE_BYTE, sid, len[15:8], len[7:0]};
      foreach (body[i]) pkt_bytes.push_back(body[i]);
      // broken start code
      if (kind >= 88) begin
         idx = $urandom_range(2);
         pkt_bytes[idx] = pkt_bytes[idx] ^ 8'($urandom_range(1, 255));
      end
      // packet cut short
      if (kind >= 70 && kind < 80) begin
         cut = $urandom_range(1, pkt_bytes.size());
         while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
      end
   endfunction

   initial begin
      int target;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed packets, no idling
      // lone non-zero byte: bad start code
      pkt_bytes = {8'hFF};
      send_packet();
      // packet ends inside the prefix
      pkt_bytes = {8'h00, 8'h00, 8'h01, 8'hE0};
      send_packet();
      // private stream 2 with one payload byte, declared length too long
      pkt_bytes = {8'h00, 8'h00, 8'h01, SID_PRIVATE2, 8'h00, 8'h02, 8'hFF};
      send_packet();
      // optional header without the '10' marker
      pkt_bytes = {8'h00, 8'h00, 8'h01, 8'hC0, 8'h00, 8'h00, 8'h3F};
      send_packet();
      // dts without pts, all-ones field, header ends on the final byte
      pkt_bytes = {8'h00, 8'h00, 8'h01, 8'hE0, 8'h00, 8'h00, 8'hBF, 8'h7F, 8'h05,
                   8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_packet();
      drain();

      // random traffic in four flow-control phases
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = send_mix[ph];
         stall_pct     = stall_mix[ph];
         target        = bytes_sent + 220;
         while (bytes_sent < target) begin
            build_random_packet();
            send_packet();
         end
         drain();
      end

      stall_pct = 0;
      repeat (8) @(negedge clock);
      $display("covered %0d packets, %0d bytes, %0d result words checked", packets_sent,
               bytes_sent, checked_count);
      $display("flow control: free running, sender idling, receiver stalling, both");
      if (fail_count == 0 && expect_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// File: sim.f
rtl/pes_pkg.sv
rtl/pes_front.sv
rtl/pes_queue.sv
rtl/pes_back.sv
rtl/pes_header_parser.sv
test/pes_result_checker.sv
test/testbench.sv
